>>> hw/rtl/tsc_pkg.sv
// Shared types and constants for the topological sort block.
`timescale 1ns / 1ps
package tsc_pkg;
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    localparam logic [1:0] ST_VERTEX  = 2'd0;
    localparam logic [1:0] ST_CYCLE   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // Configuration register byte addresses.
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_edge;    // store the captured edge
        logic clear_marks; // clear visited/on-path marks and the order count
        logic seed;        // start a walk at the start-vertex counter
        logic step;        // advance the walk by one step phase
        logic next_start;  // move the start-vertex counter up by one
        logic emit_load;   // load the output pointer from the order count
        logic emit_pop;    // move the output pointer down by one
        logic clear_store; // end of run: empty all lists
    } tsc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_busy;   // walk stack is not empty
        logic cycle;       // back edge seen
        logic start_done;  // start counter has reached the used vertex count
        logic start_seen;  // vertex under the start counter is visited
        logic count_zero;  // vertex count is zero
        logic dropped;     // an edge was dropped since the last run
        logic emit_last;   // the output pointer is at the final entry
    } tsc_stat_t;
endpackage

>>> hw/rtl/tsc_datapath.sv
// Edge store, walk stack, marks and order stack of the topological sort.
`timescale 1ns / 1ps
module tsc_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [6:0]         vertex_count,
    input  logic [6:0]         from_vertex,
    input  logic [6:0]         to_vertex,
    input  tsc_pkg::tsc_cmd_t  cmd,
    output tsc_pkg::tsc_stat_t stat,
    output logic [6:0]         out_vertex
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int DW = $clog2(MAX_VERTICES + 1);

    // Walk step phases: stack top read, edge read, target head read, act.
    localparam logic [1:0] PH_TOP  = 2'd0;
    localparam logic [1:0] PH_HEAD = 2'd2;
    localparam logic [1:0] PH_ACT  = 2'd3;

    // Edge store and list tails: memories, written and read in clocked blocks.
    logic [VW-1:0] edge_target_mem [MAX_EDGES];
    logic [CW-1:0] edge_next_mem   [MAX_EDGES];
    logic [CW-1:0] list_head_mem   [MAX_VERTICES];
    logic [EW-1:0] list_tail_mem   [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] head_valid_reg;
    logic [CW-1:0] walk_cursor_mem [MAX_VERTICES];
    logic [VW-1:0] walk_vertex_mem [MAX_VERTICES];
    logic [VW-1:0] order_mem       [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] visited_reg, on_path_reg;
    logic [CW-1:0] edge_total_reg;
    logic          dropped_reg;
    logic [DW-1:0] depth_reg, done_reg, emit_ptr_reg;
    logic [DW:0]   start_reg;
    logic          cycle_reg;
    logic [1:0]    phase_reg;

    // Used vertex count, clipped to capacity.
    logic [DW:0] n_used;
    always_comb begin
        if ({{(DW+1 > 7 ? DW+1-7 : 0){1'b0}}, vertex_count} > (DW+1 > 7 ? DW+1 : 7)'(MAX_VERTICES))
            n_used = (DW+1)'(MAX_VERTICES);
        else
            n_used = (DW+1)'(vertex_count);
    end

    // Edge add checks.
    logic edge_ok;
    logic [VW-1:0] f_idx, t_idx;
    assign f_idx = VW'(from_vertex - 7'd1);
    assign t_idx = VW'(to_vertex - 7'd1);
    assign edge_ok = (from_vertex != 7'd0) && ((DW+1)'(from_vertex) <= n_used)
        && (to_vertex != 7'd0) && ((DW+1)'(to_vertex) <= n_used)
        && (from_vertex <= 7'(MAX_VERTICES)) && (to_vertex <= 7'(MAX_VERTICES))
        && (edge_total_reg < CW'(MAX_EDGES));

    // Head/tail lookup for an edge add is a registered read: the top presents
    // the incoming source vertex at the accepting edge, so the lookup is
    // ready in the add cycle.
    logic [CW-1:0] add_head_q;
    logic [EW-1:0] add_tail_q;
    logic          add_head_v_q;
    always_ff @(posedge aclk) begin
        add_head_q   <= list_head_mem[f_idx];
        add_tail_q   <= list_tail_mem[f_idx];
        add_head_v_q <= head_valid_reg[f_idx];
    end

    // Walk top-of-stack registered reads.
    logic [DW-1:0] top_idx;
    assign top_idx = DW'(depth_reg - DW'(1));
    logic [CW-1:0] top_cursor_q;
    logic [VW-1:0] top_vertex_q;
    always_ff @(posedge aclk) begin
        top_cursor_q <= walk_cursor_mem[top_idx[VW-1:0]];
        top_vertex_q <= walk_vertex_mem[top_idx[VW-1:0]];
    end

    // Edge entry read at the registered top cursor.
    logic [VW-1:0] e_target_q;
    logic [CW-1:0] e_next_q;
    always_ff @(posedge aclk) begin
        e_target_q <= edge_target_mem[top_cursor_q[EW-1:0]];
        e_next_q   <= edge_next_mem[top_cursor_q[EW-1:0]];
    end

    // Second list-head read port: edge target in the head phase, else start vertex.
    logic [VW-1:0] s_idx;
    logic [VW-1:0] walk_head_addr;
    logic [CW-1:0] walk_head_q;
    assign s_idx = start_reg[VW-1:0];
    assign walk_head_addr = (phase_reg == PH_HEAD) ? e_target_q : s_idx;
    always_ff @(posedge aclk) walk_head_q <= list_head_mem[walk_head_addr];

    // Head of the target's list for a push, and of the start vertex for a seed.
    logic [CW-1:0] t_head;
    logic [CW-1:0] s_head;
    assign t_head = head_valid_reg[e_target_q] ? walk_head_q : CW'(MAX_EDGES);
    assign s_head = head_valid_reg[s_idx] ? walk_head_q : CW'(MAX_EDGES);

    logic cur_end;
    assign cur_end = (top_cursor_q >= CW'(MAX_EDGES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= '0;
            edge_total_reg <= '0;
            dropped_reg    <= 1'b0;
            visited_reg    <= '0;
            on_path_reg    <= '0;
            depth_reg      <= '0;
            done_reg       <= '0;
            emit_ptr_reg   <= '0;
            start_reg      <= '0;
            cycle_reg      <= 1'b0;
            phase_reg      <= PH_TOP;
        end else begin
            if (cmd.add_edge) begin
                if (edge_ok) begin
                    edge_total_reg <= edge_total_reg + CW'(1);
                    if (!add_head_v_q || add_head_q >= CW'(MAX_EDGES)) begin
                        head_valid_reg[f_idx] <= 1'b1;
                    end
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.clear_marks) begin
                visited_reg <= '0;
                on_path_reg <= '0;
                done_reg    <= '0;
                start_reg   <= '0;
                cycle_reg   <= 1'b0;
                depth_reg   <= '0;
                phase_reg   <= PH_TOP;
            end
            if (cmd.next_start) start_reg <= start_reg + (DW+1)'(1);
            if (cmd.seed) begin
                visited_reg[s_idx] <= 1'b1;
                on_path_reg[s_idx] <= 1'b1;
                depth_reg          <= DW'(1);
                phase_reg          <= PH_TOP;
            end
            if (cmd.step) begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == PH_ACT) begin
                    if (cur_end) begin
                        on_path_reg[top_vertex_q] <= 1'b0;
                        if (done_reg < DW'(MAX_VERTICES)) done_reg <= done_reg + DW'(1);
                        depth_reg <= depth_reg - DW'(1);
                    end else if ((DW+1)'(e_target_q) < n_used) begin
                        if (on_path_reg[e_target_q]) begin
                            cycle_reg <= 1'b1;
                        end else if (!visited_reg[e_target_q]
                                     && depth_reg < DW'(MAX_VERTICES)) begin
                            visited_reg[e_target_q] <= 1'b1;
                            on_path_reg[e_target_q] <= 1'b1;
                            depth_reg <= depth_reg + DW'(1);
                        end
                    end
                end
            end
            if (cmd.emit_load) emit_ptr_reg <= done_reg - DW'(1);
            if (cmd.emit_pop)  emit_ptr_reg <= emit_ptr_reg - DW'(1);
            if (cmd.clear_store) begin
                head_valid_reg <= '0;
                edge_total_reg <= '0;
                dropped_reg    <= 1'b0;
            end
        end
    end

    // Memory writes.
    always_ff @(posedge aclk) begin
        if (cmd.add_edge && edge_ok) begin
            edge_target_mem[edge_total_reg[EW-1:0]] <= t_idx;
            edge_next_mem[edge_total_reg[EW-1:0]]   <= CW'(MAX_EDGES);
            if (!add_head_v_q || add_head_q >= CW'(MAX_EDGES))
                list_head_mem[f_idx] <= edge_total_reg;
            else
                edge_next_mem[add_tail_q] <= edge_total_reg;
            list_tail_mem[f_idx] <= edge_total_reg[EW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.seed) begin
            walk_vertex_mem[0] <= s_idx;
            walk_cursor_mem[0] <= s_head;
        end else if (cmd.step && phase_reg == PH_ACT && !cur_end) begin
            walk_cursor_mem[top_idx[VW-1:0]] <= e_next_q;
            if ((DW+1)'(e_target_q) < n_used && !on_path_reg[e_target_q]
                && !visited_reg[e_target_q] && depth_reg < DW'(MAX_VERTICES)) begin
                walk_vertex_mem[depth_reg[VW-1:0]] <= e_target_q;
                walk_cursor_mem[depth_reg[VW-1:0]] <= t_head;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && phase_reg == PH_ACT && cur_end && done_reg < DW'(MAX_VERTICES))
            order_mem[done_reg[VW-1:0]] <= top_vertex_q;
    end

    logic [VW-1:0] order_q;
    always_ff @(posedge aclk) order_q <= order_mem[emit_ptr_reg[VW-1:0]];
    assign out_vertex = 7'({1'b0, order_q} + (VW+1)'(1));

    assign stat.walk_busy  = (depth_reg != '0);
    assign stat.cycle      = cycle_reg;
    assign stat.start_done = (start_reg >= n_used);
    assign stat.start_seen = visited_reg[s_idx];
    assign stat.count_zero = (vertex_count == 7'd0);
    assign stat.dropped    = dropped_reg;
    assign stat.emit_last  = (emit_ptr_reg == '0);
endmodule

>>> hw/rtl/tsc_ctrl.sv
// Controller state machine of the topological sort.
`timescale 1ns / 1ps
module tsc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_op,
    output logic               in_ready,
    output logic               capture,
    input  tsc_pkg::tsc_stat_t stat,
    output tsc_pkg::tsc_cmd_t  cmd,
    output logic               out_load,
    output logic [1:0]         out_status,
    output logic               out_last,
    input  logic               out_free
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ADD   = 10'b0000000010,
        S_START = 10'b0000000100,
        S_SEED  = 10'b0000001000,
        S_WALK  = 10'b0000010000,
        S_ELOAD = 10'b0000100000,
        S_EREAD = 10'b0001000000,
        S_EMIT  = 10'b0010000000,
        S_FLAG  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] flag_reg, flag_next;

    assign in_ready = (state_reg == S_IDLE);
    assign capture  = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        flag_next  = flag_reg;
        cmd        = '0;
        out_load   = 1'b0;
        out_status = tsc_pkg::ST_VERTEX;
        out_last   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (capture) begin
                    if (in_op == tsc_pkg::OP_ADD) begin
                        state_next = S_ADD;
                    end else if (stat.count_zero) begin
                        flag_next = tsc_pkg::ST_EMPTY;  state_next = S_FLAG;
                    end else if (stat.dropped) begin
                        flag_next = tsc_pkg::ST_DROPPED; state_next = S_FLAG;
                    end else begin
                        cmd.clear_marks = 1'b1; state_next = S_START;
                    end
                end
            end
            S_ADD: begin
                cmd.add_edge = 1'b1;
                state_next   = S_IDLE;
            end
            S_START: begin
                if (stat.start_done)      state_next = S_ELOAD;
                else if (stat.start_seen) cmd.next_start = 1'b1;
                else                      state_next = S_SEED;
            end
            // Start vertex list head is read during S_START.
            S_SEED: begin
                cmd.seed = 1'b1; state_next = S_WALK;
            end
            S_WALK: begin
                if (stat.cycle) begin
                    flag_next = tsc_pkg::ST_CYCLE; state_next = S_FLAG;
                end else if (stat.walk_busy) cmd.step = 1'b1;
                else begin
                    cmd.next_start = 1'b1; state_next = S_START;
                end
            end
            S_ELOAD: begin
                cmd.emit_load = 1'b1; state_next = S_EREAD;
            end
            S_EREAD: state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = stat.emit_last;
                    if (stat.emit_last) state_next = S_DONE;
                    else begin
                        cmd.emit_pop = 1'b1; state_next = S_EREAD;
                    end
                end
            end
            S_FLAG: begin
                if (out_free) begin
                    out_load = 1'b1; out_status = flag_reg; out_last = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                cmd.clear_store = 1'b1; state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            flag_reg  <= tsc_pkg::ST_VERTEX;
        end else begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
        end
    end
endmodule

>>> hw/rtl/topological_sort_cycle_check.sv
// Top level of the topological sort with cycle check.
`timescale 1ns / 1ps
// Add-edge transactions (operation 0) read the source list's head and tail
// as the transaction is accepted, and the edge is linked in the next
// cycle. A run transaction walks the graph depth first: it checks each
// start vertex, seeds each new walk and leaves it, and each walk step is a
// stack read, an edge read, a target head read and an update, with one
// step per edge of a visited vertex and one per vertex popped. Then the
// output pointer is loaded, each vertex of reverse postorder is read and
// emitted, waiting on any output stall, and the store is cleared. Cycle,
// dropped-edge and empty-graph runs give one result with status 1, 2 or 3.
// vertex_count is written at byte address 0; the user must write it only
// while the block is idle, which the block itself does not enforce.
module topological_sort_cycle_check #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [6:0] from_vertex, [13:7] to_vertex
    input  logic        s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [6:0] vertex
    output logic [1:0]  m_tuser,  // status
    output logic        m_tlast
);
    logic [6:0] vertex_count_reg;
    logic [6:0] from_reg, to_reg;
    logic [6:0] from_sel;
    logic op_unused;

    assign pready = 1'b1;
    assign prdata = (paddr == tsc_pkg::REG_VERTEX_COUNT) ? {25'd0, vertex_count_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) vertex_count_reg <= 7'd0;
        else if (psel && penable && pwrite && pready && paddr == tsc_pkg::REG_VERTEX_COUNT)
            vertex_count_reg <= pwdata[6:0];
    end

    tsc_pkg::tsc_cmd_t  cmd;
    tsc_pkg::tsc_stat_t stat;
    logic capture, out_load, out_last;
    logic [1:0] out_status;
    logic [6:0] out_vertex;
    logic out_free;

    assign op_unused = s_tdata[15] | s_tdata[14];
    always_ff @(posedge aclk) begin
        if (capture) begin
            from_reg <= s_tdata[6:0];
            to_reg   <= s_tdata[13:7];
        end
    end
    // Source vertex straight from the bus on the accepting edge so the
    // list lookup for an add is ready in the add cycle.
    assign from_sel = capture ? s_tdata[6:0] : from_reg;

    // Output register: freed when the downstream takes the transaction.
    logic       m_valid_reg;
    logic [6:0] m_vertex_reg;
    logic [1:0] m_status_reg;
    logic       m_last_reg;
    assign out_free = !m_valid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (out_load) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
            m_vertex_reg <= (out_status == tsc_pkg::ST_VERTEX) ? out_vertex : 7'd0;
        end
    end
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {op_unused & 1'b0, m_vertex_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    tsc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_op(s_tuser), .in_ready(s_tready), .capture(capture),
        .stat(stat), .cmd(cmd),
        .out_load(out_load), .out_status(out_status), .out_last(out_last),
        .out_free(out_free)
    );

    tsc_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .vertex_count(vertex_count_reg),
        .from_vertex(from_sel), .to_vertex(to_reg),
        .cmd(cmd), .stat(stat), .out_vertex(out_vertex)
    );
endmodule

>>> tb/tsc_checker.sv
// Checker: watches the ports of the sort block, predicts its results and compares them.
`timescale 1ns / 1ps
module tsc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    localparam int NV      = 64;
    localparam int NE      = 256;
    localparam int LIST_END = NE;

    typedef struct {
        logic [6:0] vertex;
        logic [1:0] status;
        logic       last;
    } order_item_t;

    order_item_t order_q[$];

    logic [6:0] vcount;
    logic [6:0] edge_to   [NE];
    logic [8:0] edge_link [NE];
    logic [8:0] head      [NV];
    logic [7:0] tail      [NV];
    int         edge_cnt;
    logic       drop_seen;

    function automatic int used_count();
        return (vcount > NV) ? NV : int'(vcount);
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < NV; i++) begin
            head[i] = 9'(LIST_END);
            tail[i] = '0;
        end
        edge_cnt  = 0;
        drop_seen = 1'b0;
    endfunction

    function automatic void link_edge(int f, int t);
        int n;
        n = used_count();
        if (f < 1 || f > n || t < 1 || t > n || edge_cnt >= NE) begin
            drop_seen = 1'b1;
            return;
        end
        edge_to[edge_cnt]   = 7'(t - 1);
        edge_link[edge_cnt] = 9'(LIST_END);
        if (head[f-1] >= LIST_END) head[f-1] = 9'(edge_cnt);
        else edge_link[tail[f-1]] = 9'(edge_cnt);
        tail[f-1] = 8'(edge_cnt);
        edge_cnt++;
    endfunction

    function automatic void push_result(int v, logic [1:0] st, logic lst);
        order_item_t it;
        it.vertex = 7'(v);
        it.status = st;
        it.last   = lst;
        order_q = {order_q, it};
    endfunction

    // Depth-first walk; emits reverse postorder or a single status result.
    function automatic void sort_graph();
        int   n, depth, done, top, e, t;
        logic found;
        logic seen [NV];
        logic path [NV];
        int   stk_v [NV];
        int   stk_e [NV];
        int   post  [NV];
        n = used_count();
        found = 1'b0;
        done = 0;
        if (n == 0) begin
            push_result(0, tsc_pkg::ST_EMPTY, 1'b1);
        end else if (drop_seen) begin
            push_result(0, tsc_pkg::ST_DROPPED, 1'b1);
        end else begin
            for (int i = 0; i < NV; i++) begin
                seen[i] = 1'b0;
                path[i] = 1'b0;
            end
            for (int s = 0; s < n && !found; s++) begin
                if (seen[s]) continue;
                seen[s] = 1'b1;
                path[s] = 1'b1;
                stk_v[0] = s;
                stk_e[0] = head[s];
                depth = 1;
                while (depth > 0 && !found) begin
                    top = depth - 1;
                    e = stk_e[top];
                    if (e >= LIST_END) begin
                        path[stk_v[top]] = 1'b0;
                        if (done < NV) begin
                            post[done] = stk_v[top];
                            done++;
                        end
                        depth--;
                    end else begin
                        stk_e[top] = edge_link[e];
                        t = edge_to[e];
                        if (t < n) begin
                            if (path[t]) found = 1'b1;
                            else if (!seen[t] && depth < NV) begin
                                seen[t] = 1'b1;
                                path[t] = 1'b1;
                                stk_v[depth] = t;
                                stk_e[depth] = head[t];
                                depth++;
                            end
                        end
                    end
                end
            end
            if (found) push_result(0, tsc_pkg::ST_CYCLE, 1'b1);
            else for (int k = 0; k < done; k++)
                push_result(post[done-1-k] + 1, tsc_pkg::ST_VERTEX, k == done - 1);
        end
        clear_graph();
    endfunction

    always @(posedge aclk) begin
        order_item_t want;
        if (!aresetn) begin
            vcount = '0;
            clear_graph();
            order_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == tsc_pkg::REG_VERTEX_COUNT)
                vcount = pwdata[6:0];
            if (s_tvalid && s_tready) begin
                if (s_tuser == tsc_pkg::OP_ADD)
                    link_edge(int'(s_tdata[6:0]), int'(s_tdata[13:7]));
                else sort_graph();
            end
            if (m_tvalid && m_tready) begin
                if (order_q.size() == 0) begin
                    $error("unexpected result transaction: tdata=%0h tuser=%0d tlast=%0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = order_q.pop_front();
                    if (m_tdata !== {1'b0, want.vertex} || m_tuser !== want.status
                        || m_tlast !== want.last)
                        fail_count <= fail_count + 1;
                    if (m_tdata !== {1'b0, want.vertex})
                        $error("vertex: expected %0d, got %0d", want.vertex, m_tdata);
                    if (m_tuser !== want.status)
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                    if (m_tlast !== want.last)
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                end
            end
        end
        pending <= order_q.size();
    end
endmodule

>>> tb/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the topological sort block.
`timescale 1ns / 1ps
module tb;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [6:0] from_vertex, [13:7] to_vertex
    logic        s_tuser = 1'b0; // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [6:0] vertex
    logic [1:0]  m_tuser;        // status
    logic        m_tlast;

    int fail_count, pending;
    int cycles = 0;
    int burst_left = 0;
    int sent = 0;
    logic       hold_req = 1'b0;  // asks the receiver for one long hold-off
    logic       hold_done = 1'b0;
    int         hold_cnt = 0;
    int         rx_mode = 0;

    always #5 aclk = ~aclk;

    topological_sort_cycle_check u_top (.*);

    tsc_checker u_chk (.*);

    // Receiver: stall pattern changes mode now and then; one long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == 2000) hold_done <= 1'b1;
        end else begin
            if ($urandom_range(0, 60) == 0) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(logic [6:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= tsc_pkg::REG_VERTEX_COUNT;
        pwdata  <= {25'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One transaction on the input side, then maybe a gap between bursts.
    task automatic send(logic op, int f, int t);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, 7'(t), 7'(f)};
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic run_sort();
        send(tsc_pkg::OP_RUN, $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    // Drain every result, then let trailing add-edge work settle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_count(int n);
        settle();
        reg_write(7'(n));
    endtask

    // kind 0: acyclic, 1: one back edge, 2: one out-of-range edge
    task automatic graph_phase(int n, int edges, int kind);
        int m, spot, f, t;
        m = (n > 64) ? 64 : n;
        spot = (edges > 0) ? $urandom_range(0, edges - 1) : 0;
        for (int i = 0; i < edges; i++) begin
            f = $urandom_range(1, m - 1);
            t = $urandom_range(f + 1, m);
            if (i == spot && kind == 1) send(tsc_pkg::OP_ADD, t, f);
            else if (i == spot && kind == 2) begin
                if ($urandom_range(0, 1)) send(tsc_pkg::OP_ADD, 0, t);
                else send(tsc_pkg::OP_ADD, f, $urandom_range(m + 1, 127));
            end else send(tsc_pkg::OP_ADD, f, t);
        end
        run_sort();
    endtask

    initial begin
        int n, cur;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        run_sort();                       // empty graph, count 0
        set_count(1);
        run_sort();                       // single vertex
        set_count(3);
        send(tsc_pkg::OP_ADD, 1, 2); send(tsc_pkg::OP_ADD, 2, 3); run_sort();
        send(tsc_pkg::OP_ADD, 3, 1); send(tsc_pkg::OP_ADD, 1, 2); run_sort();   // order 3,1,2
        send(tsc_pkg::OP_ADD, 1, 2); send(tsc_pkg::OP_ADD, 2, 1); run_sort();   // cycle
        send(tsc_pkg::OP_ADD, 2, 2); run_sort();                                // self loop
        send(tsc_pkg::OP_ADD, 0, 1); send(tsc_pkg::OP_ADD, 1, 127); run_sort(); // dropped
        set_count(64);
        send(tsc_pkg::OP_ADD, 64, 1); send(tsc_pkg::OP_ADD, 1, 64); run_sort(); // cycle at ends
        send(tsc_pkg::OP_ADD, 2, 60); send(tsc_pkg::OP_ADD, 60, 5);
        set_count(4);                                         // count lowered after load
        run_sort();
        set_count(127);                                       // acts as 64
        send(tsc_pkg::OP_ADD, 64, 63); run_sort();
        cur = 127;

        // Capacity overflow: one edge past the store size
        set_count(64);
        cur = 64;
        graph_phase(64, 257, 0);

        // Long receiver hold-off while the sender keeps offering
        set_count(40);
        cur = 40;
        hold_req <= 1'b1;
        graph_phase(40, 20, 0);
        graph_phase(40, 10, 0);

        // Random part
        while (sent < 380) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: n = 2;
                    1: n = 64;
                    2: n = 127;
                    default: n = $urandom_range(2, 12);
                endcase
                if (n != cur) begin
                    set_count(n);
                    cur = n;
                end
            end
            case ($urandom_range(0, 9))
                0, 1: graph_phase(cur, $urandom_range(1, 15), 1);
                2:    graph_phase(cur, $urandom_range(1, 10), 2);
                3:    begin
                          set_count(0);
                          run_sort();
                          set_count(cur);
                      end
                default: graph_phase(cur, $urandom_range(0, 20), 0);
            endcase
        end

        settle();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
